### hw/rtl/haversine_distance_core_defines.svh
// assertion macros for the haversine distance core
`ifndef HAVERSINE_DISTANCE_CORE_DEFINES_SVH
`define HAVERSINE_DISTANCE_CORE_DEFINES_SVH

// property that holds at every edge outside reset
`define HVD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence in the cycle after the antecedent
`define HVD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/hvd_pkg.sv
// shared types, constants and elaboration-time tables for the haversine core
package hvd_pkg;

  typedef logic signed [63:0] q60_t;
  typedef logic [63:0] u64_t;

  typedef struct packed {
    logic c0;
    logic c1;
  } cos_neg_t;

  localparam int CORDIC_STAGES = 32;
  localparam int FRONT_LAT = 4;
  localparam int MUL_LAT = 4;
  localparam int SQRT_STEPS = 64;
  localparam int PIPE_LAT = FRONT_LAT + CORDIC_STAGES + 1 + 2 * MUL_LAT + 2 + SQRT_STEPS
                            + CORDIC_STAGES + 2;
  localparam int A_STAGE = FRONT_LAT + CORDIC_STAGES + 1 + 2 * MUL_LAT;

  localparam u64_t PI_Q60 = 64'h3243_F6A8_885A_308D;
  localparam u64_t ONE_Q60 = 64'h1000_0000_0000_0000;
  localparam logic [31:0] DEG90 = 32'd754974720;
  localparam logic [31:0] DEG180 = 32'd1509949440;
  localparam u64_t RAD_PER_UNIT = 64'(({64'd0, PI_Q60} * 128'd128) / 128'd45);
  localparam u64_t GAIN_SEED = 64'(({64'd0, ONE_Q60} * 128'd3) / 128'd5);
  localparam logic [95:0] DIST_RND = 96'd1 << 58;
  localparam logic [31:0] RADIUS_RESET = 32'd417647821;

  function automatic u64_t mul_shr(input u64_t a, input u64_t b, input int s);
    logic [127:0] pr;
    pr = {64'd0, a} * {64'd0, b};
    return 64'(pr >> s);
  endfunction

  function automatic u64_t long_div(input u64_t num, input u64_t den);
    logic [64:0] rem;
    u64_t q;
    rem = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) from the alternating series, each term truncated; pi/4 for i = 0
  function automatic u64_t atan_q60(input int i);
    u64_t acc;
    u64_t n;
    u64_t term;
    int k;
    logic neg;
    acc = '0;
    n = 64'd1;
    k = i;
    neg = 1'b0;
    if (i == 0) begin
      acc = PI_Q60 >> 2;
    end else begin
      while (k <= 60) begin
        term = long_div(64'd1 << (60 - k), n);
        acc = neg ? acc - term : acc + term;
        neg = !neg;
        n = n + 64'd2;
        k = k + 2 * i;
      end
    end
    return acc;
  endfunction

  // 1/sqrt(gain) by newton steps from 0.6
  function automatic u64_t inv_gain_q60();
    u64_t p;
    u64_t z;
    u64_t u;
    p = ONE_Q60;
    z = GAIN_SEED;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (2 * i < 63) begin
        p = p + (p >> (2 * i));
      end
    end
    for (int j = 0; j < 6; j++) begin
      u = mul_shr(p, mul_shr(z, z, 60), 60);
      z = mul_shr(z, 64'd3 * ONE_Q60 - u, 61);
    end
    return z;
  endfunction

  localparam u64_t INV_GAIN = inv_gain_q60();

endpackage

### hw/rtl/hvd_front.sv
// angle differences, folding into the first quadrant and degree to radian scaling
module hvd_front (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [30:0]      start_longitude,
  input  logic signed [29:0]      start_latitude,
  input  logic signed [30:0]      end_longitude,
  input  logic signed [29:0]      end_latitude,
  output hvd_pkg::q60_t           lat_rad,
  output hvd_pkg::q60_t           lng_rad,
  output hvd_pkg::q60_t           c0_rad,
  output hvd_pkg::q60_t           c1_rad,
  output hvd_pkg::cos_neg_t       neg
);
  import hvd_pkg::*;

  logic [30:0] dlat;
  logic [31:0] dlng;
  logic [30:0] dbl0;
  logic [30:0] dbl1;
  logic [30:0] m_lat;
  logic [31:0] m_lng;
  logic [30:0] m_c0;
  logic [30:0] m_c1;
  logic [31:0] t_lng;
  logic [31:0] f_lat;
  logic [31:0] f_lng;
  logic [31:0] f_c0;
  logic [31:0] f_c1;
  logic [29:0] fa [4];
  logic [61:0] plo [4];
  logic [61:0] phi [4];
  q60_t rad [4];
  cos_neg_t neg_f;
  cos_neg_t neg_p;
  cos_neg_t neg_r;

  assign dlat = {end_latitude[29], end_latitude} - {start_latitude[29], start_latitude};
  assign dlng = {end_longitude[30], end_longitude} - {start_longitude[30], start_longitude};
  assign dbl0 = {start_latitude, 1'b0};
  assign dbl1 = {end_latitude, 1'b0};

  // magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      m_lat <= dlat[30] ? 31'(-dlat) : dlat;
      m_lng <= dlng[31] ? 32'(-dlng) : dlng;
      m_c0  <= dbl0[30] ? 31'(-dbl0) : dbl0;
      m_c1  <= dbl1[30] ? 31'(-dbl1) : dbl1;
    end
  end

  // fold into [0, 90] degrees
  always_comb begin
    f_lat = ({1'b0, m_lat} > DEG90) ? DEG180 - {1'b0, m_lat} : {1'b0, m_lat};
    t_lng = (m_lng >= DEG180) ? m_lng - DEG180 : m_lng;
    f_lng = (t_lng > DEG90) ? DEG180 - t_lng : t_lng;
    f_c0  = ({1'b0, m_c0} > DEG90) ? DEG180 - {1'b0, m_c0} : {1'b0, m_c0};
    f_c1  = ({1'b0, m_c1} > DEG90) ? DEG180 - {1'b0, m_c1} : {1'b0, m_c1};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fa[0] <= f_lat[29:0];
      fa[1] <= f_lng[29:0];
      fa[2] <= f_c0[29:0];
      fa[3] <= f_c1[29:0];
      neg_f.c0 <= ({1'b0, m_c0} > DEG90);
      neg_f.c1 <= ({1'b0, m_c1} > DEG90);
      neg_p <= neg_f;
      neg_r <= neg_p;
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [95:0] sum;
    assign sum = {34'd0, plo[l]} + {2'd0, phi[l], 32'd0};
    always_ff @(posedge clk) begin
      if (en) begin
        plo[l] <= fa[l] * RAD_PER_UNIT[31:0];
        phi[l] <= fa[l] * RAD_PER_UNIT[63:32];
        rad[l] <= q60_t'(sum[95:32]);
      end
    end
  end

  assign lat_rad = rad[0];
  assign lng_rad = rad[1];
  assign c0_rad = rad[2];
  assign c1_rad = rad[3];
  assign neg = neg_r;

endmodule

### hw/rtl/hvd_rot.sv
// rotation cordic, one stage per register
module hvd_rot (
  input  logic          clk,
  input  logic          en,
  input  logic          want_cos,
  input  hvd_pkg::q60_t angle,
  output hvd_pkg::q60_t result
);
  import hvd_pkg::*;

  q60_t xs [1:CORDIC_STAGES];
  q60_t ys [1:CORDIC_STAGES];
  q60_t zs [1:CORDIC_STAGES-1];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam q60_t ATAN_I = q60_t'(atan_q60(i));
    q60_t xi;
    q60_t yi;
    q60_t zi;
    if (i == 0) begin : g_first
      assign xi = q60_t'(INV_GAIN);
      assign yi = '0;
      assign zi = angle;
    end else begin : g_next
      assign xi = xs[i];
      assign yi = ys[i];
      assign zi = zs[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[63]) begin
          xs[i+1] <= xi - (yi >>> i);
          ys[i+1] <= yi + (xi >>> i);
        end else begin
          xs[i+1] <= xi + (yi >>> i);
          ys[i+1] <= yi - (xi >>> i);
        end
      end
    end
    if (i < CORDIC_STAGES - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (en) begin
          zs[i+1] <= zi[63] ? zi + ATAN_I : zi - ATAN_I;
        end
      end
    end
  end

  assign result = want_cos ? xs[CORDIC_STAGES] : ys[CORDIC_STAGES];

endmodule

### hw/rtl/hvd_mul.sv
// signed q60 product truncated toward zero, 32x32 partial products
module hvd_mul (
  input  logic          clk,
  input  logic          en,
  input  hvd_pkg::q60_t a,
  input  hvd_pkg::q60_t b,
  output hvd_pkg::q60_t p
);
  import hvd_pkg::*;

  u64_t am;
  u64_t bm;
  logic sg0;
  logic sg1;
  logic sg2;
  u64_t pp00;
  u64_t pp01;
  u64_t pp10;
  u64_t pp11;
  logic [127:0] sum;
  u64_t mag;
  q60_t prod;

  assign sum = {64'd0, pp00} + {32'd0, pp01, 32'd0} + {32'd0, pp10, 32'd0} + {pp11, 64'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      am   <= a[63] ? u64_t'(-a) : u64_t'(a);
      bm   <= b[63] ? u64_t'(-b) : u64_t'(b);
      sg0  <= a[63] ^ b[63];
      pp00 <= am[31:0] * bm[31:0];
      pp01 <= am[31:0] * bm[63:32];
      pp10 <= am[63:32] * bm[31:0];
      pp11 <= am[63:32] * bm[63:32];
      sg1  <= sg0;
      mag  <= sum[123:60];
      sg2  <= sg1;
      prod <= sg2 ? q60_t'(-mag) : q60_t'(mag);
    end
  end

  assign p = prod;

endmodule

### hw/rtl/hvd_sqrt.sv
// truncated square root of radicand * 2^60, one root bit per stage
module hvd_sqrt (
  input  logic          clk,
  input  logic          en,
  input  hvd_pkg::u64_t radicand,
  output hvd_pkg::u64_t root
);
  import hvd_pkg::*;

  u64_t rem [1:SQRT_STEPS-1];
  u64_t rt [1:SQRT_STEPS];
  logic [127:0] v [1:SQRT_STEPS-1];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    u64_t remi;
    u64_t rti;
    logic [127:0] vi;
    u64_t remn;
    u64_t trial;
    logic take;
    if (k == 0) begin : g_first
      assign remi = '0;
      assign rti = '0;
      assign vi = {4'd0, radicand, 60'd0};
    end else begin : g_next
      assign remi = rem[k];
      assign rti = rt[k];
      assign vi = v[k];
    end
    assign remn = {remi[61:0], vi[127:126]};
    assign trial = {rti[61:0], 2'b01};
    assign take = (remn >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        rt[k+1] <= {rti[62:0], take};
      end
    end
    if (k < SQRT_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= take ? remn - trial : remn;
          v[k+1] <= {vi[125:0], 2'b00};
        end
      end
    end
  end

  assign root = rt[SQRT_STEPS];

endmodule

### hw/rtl/hvd_vec.sv
// vectoring cordic giving atan(y/x), one stage per register
module hvd_vec (
  input  logic          clk,
  input  logic          en,
  input  hvd_pkg::u64_t x0,
  input  hvd_pkg::u64_t y0,
  output hvd_pkg::q60_t angle
);
  import hvd_pkg::*;

  q60_t xs [1:CORDIC_STAGES-1];
  q60_t ys [1:CORDIC_STAGES-1];
  q60_t zs [1:CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam q60_t ATAN_I = q60_t'(atan_q60(i));
    q60_t xi;
    q60_t yi;
    q60_t zi;
    if (i == 0) begin : g_first
      assign xi = q60_t'(x0);
      assign yi = q60_t'(y0);
      assign zi = '0;
    end else begin : g_next
      assign xi = xs[i];
      assign yi = ys[i];
      assign zi = zs[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        zs[i+1] <= yi[63] ? zi - ATAN_I : zi + ATAN_I;
      end
    end
    if (i < CORDIC_STAGES - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (en) begin
          if (!yi[63]) begin
            xs[i+1] <= xi + (yi >>> i);
            ys[i+1] <= yi - (xi >>> i);
          end else begin
            xs[i+1] <= xi - (yi >>> i);
            ys[i+1] <= yi + (xi >>> i);
          end
        end
      end
    end
  end

  assign angle = zs[CORDIC_STAGES];

endmodule

### hw/rtl/haversine_distance_core.sv
// top level of the haversine great-circle distance pipeline
`include "haversine_distance_core_defines.svh"

// Takes one pair of points per cycle and returns the great-circle distance
// in 2^-16 km units, in order. The latency is set by the two cordic chains
// and the 64-step square root, all fully pipelined. The whole pipeline holds
// while a result beat waits with result_ready low; sphere_radius is applied
// at the last stage and is to be written by the user between runs, which the
// block itself does not enforce.
module haversine_distance_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               point_valid,
  output logic               point_ready,
  input  logic signed [30:0] start_longitude,
  input  logic signed [29:0] start_latitude,
  input  logic signed [30:0] end_longitude,
  input  logic signed [29:0] end_latitude,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [33:0]        distance,
  input  logic               radius_we,
  input  logic [31:0]        radius_wdata
);
  import hvd_pkg::*;

  logic en;
  logic [PIPE_LAT-1:0] vld;
  logic [31:0] sphere_radius;
  q60_t lat_rad;
  q60_t lng_rad;
  q60_t c0_rad;
  q60_t c1_rad;
  cos_neg_t neg_front;
  cos_neg_t negd [CORDIC_STAGES];
  q60_t rs1;
  q60_t rs2;
  q60_t rc0;
  q60_t rc1;
  q60_t s1r;
  q60_t s2r;
  q60_t c0r;
  q60_t c1r;
  q60_t p1;
  q60_t c01;
  q60_t s22;
  q60_t p1d [MUL_LAT];
  q60_t prod;
  q60_t a_sum;
  u64_t ua;
  u64_t ua_d;
  u64_t om;
  u64_t root_a;
  u64_t root_om;
  q60_t zang;
  u64_t zc;
  u64_t plo;
  u64_t phi;
  logic [95:0] dsum;

  assign en = !result_valid || result_ready;
  assign point_ready = en;
  assign result_valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      sphere_radius <= RADIUS_RESET;
    end else begin
      if (en) begin
        vld <= {vld[PIPE_LAT-2:0], point_valid};
      end
      if (radius_we) begin
        sphere_radius <= radius_wdata;
      end
    end
  end

  hvd_front u_front (
    .clk             (clk),
    .en              (en),
    .start_longitude (start_longitude),
    .start_latitude  (start_latitude),
    .end_longitude   (end_longitude),
    .end_latitude    (end_latitude),
    .lat_rad         (lat_rad),
    .lng_rad         (lng_rad),
    .c0_rad          (c0_rad),
    .c1_rad          (c1_rad),
    .neg             (neg_front)
  );

  hvd_rot u_rot_lat (.clk(clk), .en(en), .want_cos(1'b0), .angle(lat_rad), .result(rs1));
  hvd_rot u_rot_lng (.clk(clk), .en(en), .want_cos(1'b0), .angle(lng_rad), .result(rs2));
  hvd_rot u_rot_c0 (.clk(clk), .en(en), .want_cos(1'b1), .angle(c0_rad), .result(rc0));
  hvd_rot u_rot_c1 (.clk(clk), .en(en), .want_cos(1'b1), .angle(c1_rad), .result(rc1));

  always_ff @(posedge clk) begin
    if (en) begin
      negd[0] <= neg_front;
      for (int k = 1; k < CORDIC_STAGES; k++) begin
        negd[k] <= negd[k-1];
      end
      s1r <= rs1;
      s2r <= rs2;
      c0r <= negd[CORDIC_STAGES-1].c0 ? -rc0 : rc0;
      c1r <= negd[CORDIC_STAGES-1].c1 ? -rc1 : rc1;
    end
  end

  hvd_mul u_mul_s1 (.clk(clk), .en(en), .a(s1r), .b(s1r), .p(p1));
  hvd_mul u_mul_cc (.clk(clk), .en(en), .a(c0r), .b(c1r), .p(c01));
  hvd_mul u_mul_s2 (.clk(clk), .en(en), .a(s2r), .b(s2r), .p(s22));
  hvd_mul u_mul_b (.clk(clk), .en(en), .a(c01), .b(s22), .p(prod));

  assign a_sum = p1d[MUL_LAT-1] + prod;

  // align p1 with the product, clamp a to [0, 1] and form 1 - a
  always_ff @(posedge clk) begin
    if (en) begin
      p1d[0] <= p1;
      for (int k = 1; k < MUL_LAT; k++) begin
        p1d[k] <= p1d[k-1];
      end
      if (a_sum[63]) begin
        ua <= '0;
      end else if (u64_t'(a_sum) > ONE_Q60) begin
        ua <= ONE_Q60;
      end else begin
        ua <= u64_t'(a_sum);
      end
      ua_d <= ua;
      om <= ONE_Q60 - ua;
    end
  end

  hvd_sqrt u_sqrt_a (.clk(clk), .en(en), .radicand(ua_d), .root(root_a));
  hvd_sqrt u_sqrt_om (.clk(clk), .en(en), .radicand(om), .root(root_om));

  hvd_vec u_vec (.clk(clk), .en(en), .x0(root_om), .y0(root_a), .angle(zang));

  assign zc = zang[63] ? '0 : u64_t'(zang);
  assign dsum = {32'd0, plo} + {phi, 32'd0} + DIST_RND;

  always_ff @(posedge clk) begin
    if (en) begin
      plo <= zc[31:0] * sphere_radius;
      phi <= zc[63:32] * sphere_radius;
      distance <= dsum[92:59];
    end
  end

  `HVD_ASSERT_NEXT(a_stall_freeze, !en, $stable(vld), "pipeline valids moved during a stall")
  `HVD_ASSERT_NEXT(a_radius_write, radius_we, sphere_radius == $past(radius_wdata),
    "radius write not taken")
  `HVD_ASSERT(a_clamp, vld[A_STAGE] |-> (ua <= ONE_Q60), "haversine term above one")

endmodule

### tb/tb_top.sv
// testbench for haversine_distance_core: fixed-point distance predictor, scoreboard, random traffic
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hvd_pkg::*;

  localparam longint ARC90  = 64'd754974720;
  localparam longint ARC180 = 64'd1509949440;
  localparam longint ARC360 = 64'd3019898880;
  localparam logic [63:0] MASK34 = (64'd1 << 34) - 64'd1;

  typedef struct {
    logic [30:0] lng0;
    logic [29:0] lat0;
    logic [30:0] lng1;
    logic [29:0] lat1;
    bit          set_r;
    logic [31:0] radius;
    bit          has_exp;
    logic [33:0] exp_dist;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               point_valid = 1'b0;
  logic               point_ready;
  logic signed [30:0] start_longitude = '0;
  logic signed [29:0] start_latitude = '0;
  logic signed [30:0] end_longitude = '0;
  logic signed [29:0] end_latitude = '0;
  logic               result_valid;
  logic               result_ready = 1'b1;
  logic [33:0]        distance;
  logic               radius_we = 1'b0;
  logic [31:0]        radius_wdata = '0;

  logic [63:0] atan_lut [CORDIC_STAGES];
  logic [63:0] start_gain;
  logic [31:0] cur_radius = RADIUS_RESET;
  logic [33:0] dist_q [$];
  int          err_cnt = 0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  int          stall_cnt = 0;

  haversine_distance_core u_dut (
    .clk             (clk),
    .rst             (rst),
    .point_valid     (point_valid),
    .point_ready     (point_ready),
    .start_longitude (start_longitude),
    .start_latitude  (start_latitude),
    .end_longitude   (end_longitude),
    .end_latitude    (end_latitude),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .distance        (distance),
    .radius_we       (radius_we),
    .radius_wdata    (radius_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  function automatic logic [63:0] mul_shr_q(input logic [63:0] a, input logic [63:0] b,
                                            input int s, input bit rnd);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (rnd) p = p + (128'd1 << (s - 1));
    return 64'(p >> s);
  endfunction

  function automatic longint smul_q60(input longint a, input longint b);
    logic [63:0] ua;
    logic [63:0] ub;
    longint r;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    r = longint'(mul_shr_q(ua, ub, 60, 1'b0));
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic logic [63:0] root128(input logic [127:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] trial;
    rem = '0;
    root = '0;
    for (int k = 0; k < 64; k++) begin
      rem = (rem << 2) | 64'(v[127 - 2 * k -: 2]);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic void build_consts();
    logic [63:0] acc;
    logic [63:0] n;
    logic [63:0] p;
    logic [63:0] z;
    logic [63:0] u;
    int k;
    bit neg;
    atan_lut[0] = PI_Q60 >> 2;
    for (int i = 1; i < CORDIC_STAGES; i++) begin
      acc = '0;
      n = 64'd1;
      k = i;
      neg = 1'b0;
      while (k <= 60) begin
        acc = neg ? acc - (64'd1 << (60 - k)) / n : acc + (64'd1 << (60 - k)) / n;
        neg = !neg;
        n = n + 64'd2;
        k = k + 2 * i;
      end
      atan_lut[i] = acc;
    end
    p = ONE_Q60;
    z = (64'd3 * ONE_Q60) / 64'd5;
    for (int i = 0; i < CORDIC_STAGES; i++)
      if (2 * i < 63) p = p + (p >> (2 * i));
    for (int j = 0; j < 6; j++) begin
      u = mul_shr_q(p, mul_shr_q(z, z, 60, 1'b0), 60, 1'b0);
      z = mul_shr_q(z, 64'd3 * ONE_Q60 - u, 61, 1'b0);
    end
    start_gain = z;
  endfunction

  function automatic void cordic_rot(input longint arc, output longint cv, output longint sv);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    logic [63:0] rpu;
    rpu = 64'(({64'd0, PI_Q60} * 128'd128) / 128'd45);
    x = longint'(start_gain);
    y = 0;
    z = longint'(mul_shr_q(64'(arc), rpu, 32, 1'b0));
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_lut[i]);
      end else begin
        x += dx; y -= dy; z += longint'(atan_lut[i]);
      end
    end
    cv = x;
    sv = y;
  endfunction

  function automatic longint fold_half(input longint v);
    longint m;
    m = (v < 0 ? -v : v) % ARC180;
    if (m > ARC90) m = ARC180 - m;
    return m;
  endfunction

  function automatic longint fold_full(input longint v, output bit neg);
    longint m;
    m = (v < 0 ? -v : v) % ARC360;
    if (m > ARC180) m = ARC360 - m;
    neg = 1'b0;
    if (m > ARC90) begin
      m = ARC180 - m;
      neg = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [33:0] predict_distance(input logic [30:0] lng0, input logic [29:0] lat0,
                                                   input logic [30:0] lng1, input logic [29:0] lat1,
                                                   input logic [31:0] radius);
    longint sl0;
    longint sa0;
    longint sl1;
    longint sa1;
    longint s1;
    longint s2;
    longint c0;
    longint c1;
    longint unused;
    longint hav;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    logic [63:0] ua;
    bit n0;
    bit n1;
    sl0 = longint'($signed(lng0));
    sa0 = longint'($signed(lat0));
    sl1 = longint'($signed(lng1));
    sa1 = longint'($signed(lat1));
    cordic_rot(fold_half(sa1 - sa0), unused, s1);
    cordic_rot(fold_half(sl1 - sl0), unused, s2);
    cordic_rot(fold_full(2 * sa0, n0), c0, unused);
    cordic_rot(fold_full(2 * sa1, n1), c1, unused);
    if (n0) c0 = -c0;
    if (n1) c1 = -c1;
    hav = smul_q60(s1, s1) + smul_q60(smul_q60(c0, c1), smul_q60(s2, s2));
    if (hav < 0) hav = 0;
    if (hav > longint'(ONE_Q60)) hav = longint'(ONE_Q60);
    ua = 64'(hav);
    y = longint'(root128({64'd0, ua} << 60));
    x = longint'(root128({64'd0, ONE_Q60 - ua} << 60));
    z = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(atan_lut[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(atan_lut[i]);
      end
    end
    if (z < 0) z = 0;
    return 34'(mul_shr_q(64'(z), {32'd0, radius}, 59, 1'b1) & MASK34);
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (dist_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat, distance %0d", distance));
      end else if (distance !== dist_q[0]) begin
        report_mismatch($sformatf("distance %0d, want %0d", distance, dist_q[0]));
        void'(dist_q.pop_front());
      end else begin
        void'(dist_q.pop_front());
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (recv_idle && stall_cnt == 0 && $urandom_range(0, 7) == 0)
        stall_cnt = $urandom_range(1, 6);
      if (stall_cnt > 0) begin
        result_ready <= 1'b0;
        stall_cnt--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  task automatic drain_results();
    while (dist_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_radius(input logic [31:0] value);
    drain_results();
    repeat (8) @(posedge clk);
    radius_we <= 1'b1;
    radius_wdata <= value;
    @(posedge clk);
    radius_we <= 1'b0;
    cur_radius = value;
  endtask

  task automatic send_point(input logic [30:0] lng0, input logic [29:0] lat0,
                            input logic [30:0] lng1, input logic [29:0] lat1,
                            input bit has_exp, input logic [33:0] exp_dist);
    int gap;
    if (send_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      point_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_valid <= 1'b1;
    start_longitude <= lng0;
    start_latitude <= lat0;
    end_longitude <= lng1;
    end_latitude <= lat1;
    do @(posedge clk); while (!point_ready);
    dist_q.push_back(has_exp ? exp_dist : predict_distance(lng0, lat0, lng1, lat1, cur_radius));
  endtask

  function automatic logic [30:0] rand_lng(input int mode);
    if (mode == 0) return 31'($urandom);
    return 31'(longint'($urandom_range(0, 1509949440)) - ARC90);
  endfunction

  function automatic logic [29:0] rand_lat(input int mode);
    if (mode == 0) return 30'($urandom);
    return 30'(longint'($urandom_range(0, 754974720)) - 64'd377487360);
  endfunction

  task automatic send_random(input int count);
    int mode;
    logic [30:0] lng0;
    logic [29:0] lat0;
    logic [30:0] lng1;
    logic [29:0] lat1;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(0, 9);
      lng0 = rand_lng(mode);
      lat0 = rand_lat(mode);
      if (mode == 1) begin
        lng1 = lng0 + 31'($signed($urandom_range(0, 2000)) - 1000);
        lat1 = lat0 + 30'($signed($urandom_range(0, 2000)) - 1000);
      end else begin
        lng1 = rand_lng(mode);
        lat1 = rand_lat(mode);
      end
      send_point(lng0, lat0, lng1, lat1, 1'b0, '0);
    end
  endtask

  stim_row_t rows [$];

  initial begin
    build_consts();
    rows = '{
      '{31'd0, 30'd0, 31'd0, 30'd0, 1'b0, 32'd0, 1'b0, 34'd0},
      '{31'd0, 30'd0, 31'd754974720, 30'd0, 1'b0, 32'd0, 1'b0, 34'd0},
      '{-31'sd754974720, 30'd0, 31'd754974720, 30'd0, 1'b0, 32'd0, 1'b0, 34'd0},
      '{31'd0, 30'd377487360, 31'd0, -30'sd377487360, 1'b0, 32'd0, 1'b0, 34'd0},
      '{31'd100, 30'd377487360, 31'd754974720, 30'd377487360, 1'b0, 32'd0, 1'b0, 34'd0},
      '{31'd0, 30'd0, 31'd754974720, 30'd0, 1'b0, 32'd0, 1'b0, 34'd0},
      '{31'd0, 30'd1000, 31'd0, 30'd1001, 1'b0, 32'd0, 1'b0, 34'd0},
      '{31'd0, 30'd0, 31'd1, 30'd0, 1'b0, 32'd0, 1'b0, 34'd0},
      '{31'h4000_0000, 30'h2000_0000, 31'h3FFF_FFFF, 30'h1FFF_FFFF, 1'b0, 32'd0, 1'b0, 34'd0},
      '{31'h7FFF_FFFF, 30'h3FFF_FFFF, 31'h4000_0000, 30'h2000_0000, 1'b0, 32'd0, 1'b0, 34'd0},
      '{31'd0, 30'd500000000, 31'd0, -30'sd500000000, 1'b0, 32'd0, 1'b0, 34'd0},
      '{31'd123456789, 30'd300000000, 31'd123456789, 30'd300000000, 1'b0, 32'd0,
        1'b0, 34'd0},
      '{31'd0, 30'd0, 31'd754974720, 30'd0, 1'b1, 32'd0, 1'b1, 34'd0},
      '{-31'sd754974720, 30'd377487360, 31'd754974720, -30'sd377487360, 1'b0, 32'd0,
        1'b1, 34'd0},
      '{31'h4000_0000, 30'h2000_0000, 31'h3FFF_FFFF, 30'h1FFF_FFFF, 1'b0, 32'd0, 1'b1, 34'd0},
      '{31'd0, 30'd0, 31'd754974720, 30'd0, 1'b1, 32'hFFFF_FFFF, 1'b0, 34'd0},
      '{31'd0, 30'd377487360, 31'd0, -30'sd377487360, 1'b0, 32'd0, 1'b0, 34'd0},
      '{-31'sd754974720, 30'd1, 31'd754974720, -30'sd1, 1'b0, 32'd0, 1'b0, 34'd0},
      '{31'd0, 30'd0, 31'd0, 30'd0, 1'b1, 32'd1, 1'b0, 34'd0},
      '{31'd0, 30'd0, 31'd754974720, 30'd0, 1'b0, 32'd0, 1'b0, 34'd0},
      '{31'd0, 30'd0, 31'd754974720, 30'd0, 1'b1, RADIUS_RESET, 1'b0, 34'd0}
    };
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      if (rows[i].set_r) begin
        point_valid <= 1'b0;
        write_radius(rows[i].radius);
      end
      send_point(rows[i].lng0, rows[i].lat0, rows[i].lng1, rows[i].lat1,
                 rows[i].has_exp, rows[i].exp_dist);
    end
    send_random(250);
    point_valid <= 1'b0;
    drain_results();
    send_random(100);
    point_valid <= 1'b0;
    write_radius(32'd0);
    send_random(50);
    point_valid <= 1'b0;
    write_radius(32'hFFFF_FFFF);
    send_random(200);
    point_valid <= 1'b0;
    write_radius($urandom);
    send_random(200);
    point_valid <= 1'b0;
    write_radius(RADIUS_RESET);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_random(230);
    point_valid <= 1'b0;
    drain_results();
    repeat (PIPE_LAT + 20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
